[sv/tcce_pkg.sv]
// constants, codes and the tab stop table for the text console character engine
// no dependencies
`timescale 1ns / 1ps

package tcce_pkg;

   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int TAB_WIDTH     = 8;

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int COLX_W    = COL_W + 1;
   localparam int ROWX_W    = ROW_W + 1;
   localparam int POS_W     = 11;
   localparam int IDX_W     = 11;
   localparam int CELL_W    = 16;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 4;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W     = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 1'd1;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

   localparam logic [CELL_W-1:0]  BLANK_CELL = 16'h0F20;
   localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
   localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;

   // next tab stop for every column value
   typedef logic [COLX_W-1:0] tab_table_type [2**COL_W];

   function automatic tab_table_type build_tab_table();
      tab_table_type t;
      for (int i = 0; i < 2**COL_W; i++) begin
         t[i] = COLX_W'(((i / TAB_WIDTH) + 1) * TAB_WIDTH);
      end
      return t;
   endfunction

   localparam tab_table_type TAB_STOP = build_tab_table();

endpackage

[sv/tcce_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/text_console_char_engine.sv]
// text console character engine: cursor, color registers and a circular cell store
// every item passes the exec and done states; put with scroll adds a sweep that blanks
// SCREEN_WIDTH cells (one blanked cell a cycle), clear adds a sweep over all CELL_COUNT cells
// one item at a time, taken only when idle; sweeps are set by the single ram write port
// reset: cursor 0, colors 7 on 0, then a blanking pass over all CELL_COUNT cells with req_ready low
// depends on tcce_pkg and tcce_ram
`timescale 1ns / 1ps

module text_console_char_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tcce_pkg::MODE_W-1:0]    req_mode,
   input  logic [tcce_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcce_pkg::IDX_W-1:0]     req_cell_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tcce_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic [tcce_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic                           rsp_scrolled,
   input  logic                           csr_wr_en,
   input  logic [tcce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]   csr_wr_data
);

   import tcce_pkg::*;

   typedef enum logic [1:0] {S_FILL, S_IDLE, S_EXEC, S_DONE} state_type;

   state_type          state_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [ADDR_W-1:0]  fill_addr_ff;
   logic [ADDR_W-1:0]  fill_last_ff;
   logic               fill_resp_ff;
   logic               scroll_pend_ff;
   logic               scrolled_ff;
   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_cursor_pos_ff;
   logic [CELL_W-1:0]  rsp_cell_value_ff;
   logic               rsp_scrolled_ff;

   logic [COLX_W-1:0]  col_t;
   logic [ROWX_W-1:0]  row_t;
   logic [COL_W-1:0]   col_in;
   logic [ROW_W-1:0]   row_in;
   logic               put_wr;
   logic               scroll_hit;

   logic [SUM_W-1:0]   cur_lin;
   logic [SUM_W-1:0]   lin_sum;
   logic [SUM_W-1:0]   phys_sum;
   logic [ADDR_W-1:0]  phys_addr;
   logic               oob;
   logic [SUM_W-1:0]   base_sum;
   logic [ADDR_W-1:0]  base_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [CELL_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [CELL_W-1:0]  ram_rd_data;

   // cursor update for one put
   always_comb begin
      col_t  = {1'b0, col_ff};
      row_t  = {1'b0, row_ff};
      put_wr = 1'b0;
      case (char_ff)
         CHAR_BS: begin
            if (col_ff != '0) begin
               col_t = col_t - 1'b1;
            end
         end
         CHAR_TAB: col_t = TAB_STOP[col_ff];
         CHAR_CR:  col_t = '0;
         CHAR_LF:  row_t = row_t + 1'b1;
         default: begin
            if (char_ff >= CHAR_SPACE && char_ff <= CHAR_LAST) begin
               put_wr = 1'b1;
               col_t  = col_t + 1'b1;
            end
         end
      endcase
      if (col_t >= COLX_W'(SCREEN_WIDTH)) begin
         col_t = '0;
         row_t = row_t + 1'b1;
      end
      scroll_hit = (row_t >= ROWX_W'(SCREEN_HEIGHT));
      col_in     = col_t[COL_W-1:0];
      row_in     = scroll_hit ? ROW_W'(SCREEN_HEIGHT - 1) : row_t[ROW_W-1:0];
   end

   // shared address unit: logical cell to physical slot through the scroll base
   always_comb begin
      cur_lin  = SUM_W'(row_ff) * SUM_W'(SCREEN_WIDTH) + SUM_W'(col_ff);
      lin_sum  = (mode_ff == MODE_READ) ? SUM_W'(idx_ff) : cur_lin;
      phys_sum = lin_sum + SUM_W'(base_ff);
      if (phys_sum >= SUM_W'(CELL_COUNT)) begin
         phys_addr = ADDR_W'(phys_sum - SUM_W'(CELL_COUNT));
      end else begin
         phys_addr = ADDR_W'(phys_sum);
      end
      oob      = (SUM_W'(idx_ff) >= SUM_W'(CELL_COUNT));
      base_sum = SUM_W'(base_ff) + SUM_W'(SCREEN_WIDTH);
      base_in  = (base_sum >= SUM_W'(CELL_COUNT)) ? '0 : ADDR_W'(base_sum);
   end

   always_comb begin
      ram_wr_en   = (state_ff == S_FILL) ||
                    (state_ff == S_EXEC && mode_ff == MODE_PUT && put_wr);
      ram_wr_addr = (state_ff == S_FILL) ? fill_addr_ff : phys_addr;
      ram_wr_data = (state_ff == S_FILL) ? BLANK_CELL : {bg_ff, fg_ff, char_ff};
      ram_rd_en   = (state_ff == S_EXEC) && (mode_ff == MODE_READ) && !oob;
   end

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (phys_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_FILL;
         fill_addr_ff   <= '0;
         fill_last_ff   <= ADDR_W'(CELL_COUNT - 1);
         fill_resp_ff   <= 1'b0;
         scroll_pend_ff <= 1'b0;
         scrolled_ff    <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
         base_ff        <= '0;
         fg_ff          <= FG_RESET;
         bg_ff          <= BG_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FOREGROUND: fg_ff <= csr_wr_data;
               CSR_BACKGROUND: bg_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_FILL: begin
               if (fill_addr_ff == fill_last_ff) begin
                  if (scroll_pend_ff) begin
                     base_ff <= base_in;
                  end
                  scroll_pend_ff <= 1'b0;
                  state_ff       <= fill_resp_ff ? S_DONE : S_IDLE;
               end else begin
                  fill_addr_ff <= fill_addr_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_mode;
                  char_ff  <= req_char_code;
                  idx_ff   <= req_cell_index;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               scrolled_ff <= 1'b0;
               case (mode_ff)
                  MODE_PUT: begin
                     col_ff <= col_in;
                     row_ff <= row_in;
                     if (scroll_hit) begin
                        // blank the old top row, it becomes the new bottom row
                        fill_addr_ff   <= base_ff;
                        fill_last_ff   <= ADDR_W'(SUM_W'(base_ff) + SUM_W'(SCREEN_WIDTH - 1));
                        fill_resp_ff   <= 1'b1;
                        scroll_pend_ff <= 1'b1;
                        scrolled_ff    <= 1'b1;
                        state_ff       <= S_FILL;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
                  MODE_CLEAR: begin
                     col_ff         <= '0;
                     row_ff         <= '0;
                     base_ff        <= '0;
                     fill_addr_ff   <= '0;
                     fill_last_ff   <= ADDR_W'(CELL_COUNT - 1);
                     fill_resp_ff   <= 1'b1;
                     scroll_pend_ff <= 1'b0;
                     state_ff       <= S_FILL;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_cursor_pos_ff <= cur_lin[POS_W-1:0];
                  rsp_cell_value_ff <= (mode_ff == MODE_READ && !oob) ? ram_rd_data : '0;
                  rsp_scrolled_ff   <= scrolled_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_pos_ff;
   assign rsp_cell_value = rsp_cell_value_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   // accepted transfer always goes to execution
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("transfer not followed by execution");

   // cursor stays on screen
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < COLX_W'(SCREEN_WIDTH)) && ({1'b0, row_ff} < ROWX_W'(SCREEN_HEIGHT)))
      else $error("cursor off screen");

   // sweep never passes its last slot
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> fill_addr_ff <= fill_last_ff)
      else $error("fill sweep overran");

   // store untouched while waiting for input
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ram_wr_en)
      else $error("store written while idle");

   // a result appears only out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result without completed item");

endmodule

[tb/tb_text_console_char_engine.sv]
// self-checking testbench for text_console_char_engine: directed and random items
// checked against an in-bench console predictor, with random idling on both channels
// depends on tcce_pkg and text_console_char_engine
`timescale 1ns / 1ps

module tb_text_console_char_engine;
   import tcce_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = SCREEN_WIDTH + 16;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_value;
      logic              scrolled;
   } console_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode = MODE_PUT;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [IDX_W-1:0]     req_cell_index = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [POS_W-1:0]     rsp_cursor_pos;
   logic [CELL_W-1:0]    rsp_cell_value;
   logic                 rsp_scrolled;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FOREGROUND;
   logic [COLOR_W-1:0]   csr_wr_data = '0;

   // predictor state
   logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
   int                 cursor_col;
   int                 cursor_row;
   logic [COLOR_W-1:0] fg_colour;
   logic [COLOR_W-1:0] bg_colour;

   console_report_type pending_reports [$];
   bit                 failed = 1'b0;
   bit                 steady = 1'b0;
   bit                 hold_off_request = 1'b0;

   text_console_char_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic bit put_character(logic [CHAR_W-1:0] ch);
      bit scrolled;
      scrolled = 1'b0;
      if (ch == CHAR_BS) begin
         if (cursor_col > 0) cursor_col--;
      end else if (ch == CHAR_TAB) begin
         cursor_col = (cursor_col / TAB_WIDTH + 1) * TAB_WIDTH;
      end else if (ch == CHAR_CR) begin
         cursor_col = 0;
      end else if (ch == CHAR_LF) begin
         cursor_row++;
      end else if (ch >= CHAR_SPACE && ch <= CHAR_LAST) begin
         if (cursor_row * SCREEN_WIDTH + cursor_col < CELL_COUNT)
            shadow_cells[cursor_row * SCREEN_WIDTH + cursor_col] = {bg_colour, fg_colour, ch};
         cursor_col++;
      end
      if (cursor_col >= SCREEN_WIDTH) begin
         cursor_col = 0;
         cursor_row++;
      end
      if (cursor_row >= SCREEN_HEIGHT) begin
         // scroll up one line and blank the bottom line
         for (int i = 0; i < (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i++)
            shadow_cells[i] = shadow_cells[i + SCREEN_WIDTH];
         for (int i = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH; i < CELL_COUNT; i++)
            shadow_cells[i] = BLANK_CELL;
         cursor_row = SCREEN_HEIGHT - 1;
         scrolled = 1'b1;
      end
      return scrolled;
   endfunction

   function automatic console_report_type apply_console_item(logic [MODE_W-1:0] mode,
                                                            logic [CHAR_W-1:0] ch,
                                                            logic [IDX_W-1:0] idx);
      console_report_type report;
      int                 pos;
      report = '0;
      case (mode)
         MODE_PUT: begin
            report.scrolled = put_character(ch);
         end
         MODE_READ: begin
            if (idx < CELL_COUNT) report.cell_value = shadow_cells[idx];
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = BLANK_CELL;
            cursor_col = 0;
            cursor_row = 0;
         end
         default: ;
      endcase
      pos = cursor_row * SCREEN_WIDTH + cursor_col;
      report.cursor_pos = pos[POS_W-1:0];
      return report;
   endfunction

   task automatic reset_console_shadow();
      for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = BLANK_CELL;
      cursor_col = 0;
      cursor_row = 0;
      fg_colour  = FG_RESET;
      bg_colour  = BG_RESET;
   endtask

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
      int gap;
      gap = (!steady && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       <= mode;
      req_char_code  <= ch;
      req_cell_index <= idx;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(apply_console_item(mode, ch, idx));
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colour_register(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [COLOR_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FOREGROUND) fg_colour = data;
      else bg_colour = data;
   endtask

   task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      wait_until_idle();
      write_colour_register(CSR_FOREGROUND, fg);
      write_colour_register(CSR_BACKGROUND, bg);
   endtask

   // control byte with no cursor effect, or a byte of the upper half
   function automatic logic [CHAR_W-1:0] ignored_char();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom_range(0, 255));
      while ((ch >= CHAR_SPACE && ch <= CHAR_LAST) || ch == CHAR_BS || ch == CHAR_TAB ||
             ch == CHAR_CR || ch == CHAR_LF);
      return ch;
   endfunction

   // one item of terminal-like traffic: mostly text and line control
   task automatic send_text_item();
      int           pick;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      idx  = IDX_W'($urandom_range(0, 2**IDX_W - 1));
      if (pick < 55) send_item(MODE_PUT, CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST)), idx);
      else if (pick < 67) send_item(MODE_PUT, CHAR_LF, idx);
      else if (pick < 73) send_item(MODE_PUT, CHAR_CR, idx);
      else if (pick < 78) send_item(MODE_PUT, CHAR_TAB, idx);
      else if (pick < 82) send_item(MODE_PUT, CHAR_BS, idx);
      else if (pick < 84) send_item(MODE_PUT, ignored_char(), idx);
      else if (pick < 85) send_item(MODE_UNUSED, CHAR_W'($urandom_range(0, 255)), idx);
      else if (pick < 97 || $urandom_range(0, 2) != 0) begin
         if ($urandom_range(0, 7) == 0)
            send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(CELL_COUNT, 2**IDX_W - 1)));
         else
            send_item(MODE_READ, CHAR_W'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(0, CELL_COUNT - 1)));
      end else
         send_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)), idx);
   endtask

   task automatic test_blank_screen();
      send_item(MODE_READ, 8'h00, '0);
      send_item(MODE_READ, 8'hFF, IDX_W'(CELL_COUNT - 1));
      send_item(MODE_READ, 8'h00, IDX_W'(CELL_COUNT));
      send_item(MODE_READ, 8'hFF, '1);
   endtask

   task automatic test_character_codes();
      send_item(MODE_PUT, CHAR_SPACE, '1);
      send_item(MODE_PUT, CHAR_LAST, '0);
      send_item(MODE_PUT, 8'h41, '0);
      send_item(MODE_PUT, CHAR_BS, '0);
      send_item(MODE_PUT, CHAR_CR, '0);
      send_item(MODE_PUT, CHAR_BS, '0);
      send_item(MODE_PUT, CHAR_TAB, '0);
      send_item(MODE_PUT, CHAR_LF, '0);
      send_item(MODE_PUT, 8'h00, '0);
      send_item(MODE_PUT, 8'h1F, '0);
      send_item(MODE_PUT, 8'h80, '0);
      send_item(MODE_PUT, 8'hFF, '0);
      send_item(MODE_PUT, 8'h5A, '0);
      send_item(MODE_UNUSED, 8'h41, 11'd2);
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd1);
      send_item(MODE_READ, 8'h00, 11'd2);
      send_item(MODE_READ, 8'h00, IDX_W'(SCREEN_WIDTH + TAB_WIDTH));
      send_item(MODE_CLEAR, 8'h00, '0);
      send_item(MODE_READ, 8'h00, IDX_W'(SCREEN_WIDTH + TAB_WIDTH));
   endtask

   task automatic test_text_lines();
      repeat (200) send_text_item();
   endtask

   // tab runs and text that run past the last column
   task automatic test_line_wrap();
      repeat (3) begin
         repeat ($urandom_range(8, 10))
            send_item(MODE_PUT, CHAR_TAB, IDX_W'($urandom_range(0, 2047)));
         repeat ($urandom_range(4, 9))
            send_item(MODE_PUT, CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST)),
                      IDX_W'($urandom_range(0, 2047)));
         send_item(MODE_READ, 8'h00, IDX_W'($urandom_range(0, CELL_COUNT - 1)));
      end
   endtask

   task automatic test_receiver_hold_off();
      hold_off_request = 1'b1;
      repeat (40) send_text_item();
   endtask

   task automatic test_random_fields();
      repeat (100)
         send_item(MODE_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, 2047)));
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      repeat (60) send_text_item();
   endtask

   // result receiver with random stall bursts and one long hold-off on request
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(1, 14);
            repeat (burst - 1) @(negedge clock);
         end else
            rsp_ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      console_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result transfer cursor_pos %0d cell_value %h scrolled %b",
                     $time, rsp_cursor_pos, rsp_cell_value, rsp_scrolled);
            failed = 1'b1;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_cursor_pos !== want.cursor_pos) begin
               $display("%0t: cursor_pos expected %0d actual %0d", $time, want.cursor_pos,
                        rsp_cursor_pos);
               failed = 1'b1;
            end
            if (rsp_cell_value !== want.cell_value) begin
               $display("%0t: cell_value expected %h actual %h", $time, want.cell_value,
                        rsp_cell_value);
               failed = 1'b1;
            end
            if (rsp_scrolled !== want.scrolled) begin
               $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                        rsp_scrolled);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("** text_console_char_engine: FAILED **");
      $finish;
   end

   initial begin
      reset_console_shadow();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_blank_screen();
      test_character_codes();
      set_colours(4'd15, 4'd0);
      test_text_lines();
      set_colours(4'd0, 4'd15);
      test_line_wrap();
      test_receiver_hold_off();
      set_colours(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
      test_random_fields();
      set_colours(4'd15, 4'd15);
      test_steady_stream();

      wait_until_idle();
      if (!failed)
         $display("** text_console_char_engine: PASSED **");
      else
         $display("** text_console_char_engine: FAILED **");
      $finish;
   end

endmodule
